// ----- sv/strmax_pkg.sv -----
// Shared types, constants and helpers for the segment tree range maximum block.
// Used by the top level and the port checker; no dependencies.
package strmax_pkg;

  // Default number of leaf elements (power of two)
  localparam int unsigned LEAF_COUNT_DEF = 1024;

  // Field widths fixed by the stream format
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 10;

  // Packed stream widths
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

  // Sentinel held by every node after reset
  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // Transaction kinds carried in in_tuser
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic signed [DATA_W-1:0] node_t;

  // Larger of two signed node values
  function automatic node_t node_max(input node_t a, input node_t b);
    node_max = (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/strmax_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module strmax_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register read data every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/segment_tree_range_max_top.sv -----
// Segment tree range maximum over LEAF_COUNT signed elements; uses strmax_pkg, strmax_ram.
// Update: one tree level per cycle from leaf to root; no result.
// Query: result on out_tdata, with out_tuser set for an empty range.
// A stalled result delays the next query.
// Reset: synchronous, active low; a clearing pass then writes the sentinel to every node
// while in_tready stays low. One transaction at a time.
module segment_tree_range_max_top
  import strmax_pkg::*;
#(
  parameter int unsigned LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata, low bit up: position[9:0], new_value[41:10], range_low[51:42],
  // range_high[61:52], zero pad[63:62]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,   // mode
  // out_tdata, low bit up: range_maximum[31:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser   // empty_range
);

  localparam int unsigned LW = $clog2(LEAF_COUNT);
  localparam int unsigned AW = LW + 1;   // heap address, 1-based
  localparam int unsigned QW = LW + 2;   // walk bounds reach 2*LEAF_COUNT

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UWAIT = 3'd2;
  localparam logic [2:0] S_QL    = 3'd3;
  localparam logic [2:0] S_QR    = 3'd4;
  localparam logic [2:0] S_QFIN  = 3'd5;
  localparam logic [2:0] S_QOUT  = 3'd6;

  // Unpack input fields
  logic [INDEX_W-1:0] f_pos, f_lo, f_hi;
  node_t              f_val;
  logic [LW-1:0]      pos_idx, lo_idx, hi_idx;

  assign f_pos   = in_tdata[9:0];
  assign f_val   = in_tdata[41:10];
  assign f_lo    = in_tdata[51:42];
  assign f_hi    = in_tdata[61:52];
  assign pos_idx = LW'(f_pos);
  assign lo_idx  = LW'(f_lo);
  assign hi_idx  = LW'(f_hi);

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] n_r, n_nxt;
  node_t         v_r, v_nxt;
  logic [QW-1:0] l_r, l_nxt, r_r, r_nxt;
  node_t         best_r, best_nxt;
  logic          pend_r, pend_nxt;
  logic          empty_r, empty_nxt;
  logic          ovalid_r, ovalid_nxt;
  node_t         odata_r, odata_nxt;
  logic          ouser_r, ouser_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  node_t         ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  node_t         rd_val;

  logic          in_acc;
  logic [AW-1:0] leaf_addr, par_addr;
  logic [QW-1:0] r_dec;
  node_t         up_max;

  assign rd_val    = ram_rdata;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign leaf_addr = {1'b1, pos_idx};
  assign par_addr  = n_r >> 1;
  assign up_max    = node_max(v_r, rd_val);
  assign r_dec     = r_r - QW'(1);

  strmax_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * LEAF_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: clearing pass, leaf-to-root update, bottom-up range walk
  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    n_nxt      = n_r;
    v_nxt      = v_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    best_nxt   = pend_r ? node_max(best_r, rd_val) : best_r;
    pend_nxt   = 1'b0;
    empty_nxt  = empty_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    ram_we     = 1'b0;
    ram_waddr  = n_r;
    ram_wdata  = v_r;
    ram_raddr  = '0;

    case (st_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = MOST_NEG;
        clr_nxt   = clr_r + AW'(1);
        if (&clr_r) begin
          st_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_WRITE) begin
            // Write the leaf and fetch its sibling
            ram_we    = 1'b1;
            ram_waddr = leaf_addr;
            ram_wdata = f_val;
            ram_raddr = leaf_addr ^ AW'(1);
            n_nxt     = leaf_addr;
            v_nxt     = f_val;
            st_nxt    = S_UWAIT;
          end else if (lo_idx > hi_idx) begin
            best_nxt  = MOST_NEG;
            empty_nxt = 1'b1;
            st_nxt    = S_QOUT;
          end else begin
            l_nxt     = {2'b01, lo_idx};
            r_nxt     = {2'b01, hi_idx} + QW'(1);
            best_nxt  = MOST_NEG;
            empty_nxt = 1'b0;
            st_nxt    = S_QL;
          end
        end
      end

      S_UWAIT: begin
        // Write parent maximum, fetch the parent's sibling
        ram_we    = 1'b1;
        ram_waddr = par_addr;
        ram_wdata = up_max;
        ram_raddr = par_addr ^ AW'(1);
        n_nxt     = par_addr;
        v_nxt     = up_max;
        if (par_addr == AW'(1)) begin
          st_nxt = S_IDLE;
        end
      end

      S_QL: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            ram_raddr = l_r[AW-1:0];
            pend_nxt  = 1'b1;
            l_nxt     = l_r + QW'(1);
          end
          st_nxt = S_QR;
        end else begin
          st_nxt = S_QFIN;
        end
      end

      S_QR: begin
        if (r_r[0]) begin
          ram_raddr = r_dec[AW-1:0];
          pend_nxt  = 1'b1;
        end
        // Odd r drops to r-1; both shift to the same parent bound
        l_nxt  = l_r >> 1;
        r_nxt  = r_r >> 1;
        st_nxt = S_QL;
      end

      S_QFIN: begin
        // Fold in the last read
        st_nxt = S_QOUT;
      end

      S_QOUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = best_r;
          ouser_nxt  = empty_r;
          st_nxt     = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    v_r     <= v_nxt;
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    best_r  <= best_nxt;
    empty_r <= empty_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

// ----- sv/strmax_chk.sv -----
// Port-level checker for segment_tree_range_max_top, attached by bind.
// Depends on strmax_pkg.
module strmax_chk
  import strmax_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // Stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Empty range always carries the sentinel
  a_empty_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == MOST_NEG)
    else $error("empty range without sentinel");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An element write raises no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("result raised by element write");

endmodule

bind segment_tree_range_max_top strmax_chk u_strmax_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- bench/segment_tree_range_max_top_tb.sv -----
// Self-checking bench for segment_tree_range_max_top: element writes and range maximum queries
// on the stream ports, scored against a behavioral max array. Depends on strmax_pkg and the RTL.
module segment_tree_range_max_top_tb;
  import strmax_pkg::*;

  localparam int unsigned LEAVES        = LEAF_COUNT_DEF;
  localparam int unsigned IDLE_LIMIT    = 6000;  // covers the clearing pass and the long stall
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam node_t       MOST_POS      = 32'sh7fff_ffff;

  typedef logic [INDEX_W-1:0] index_t;

  typedef struct {
    logic   mode;
    index_t position;
    node_t  new_value;
    index_t range_low;
    index_t range_high;
  } tree_op_t;

  typedef struct {
    node_t range_maximum;
    logic  empty_range;
  } range_answer_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Predicted contents of every element and the answers still owed by the block
  node_t         element_values [LEAVES];
  range_answer_t pending_answers[$];
  range_answer_t seen_answer;

  int unsigned burst_left;
  int unsigned fail_count;
  int unsigned writes_sent;
  int unsigned queries_sent;
  int unsigned empties_sent;
  int unsigned answers_checked;
  int unsigned idle_cycles;
  int unsigned hold_left;
  bit          long_hold_req;
  logic [9:0]  rx_cycle = '0;

  segment_tree_range_max_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Largest predicted element over an inclusive, non-empty range
  function automatic node_t range_maximum_of(input index_t lo, input index_t hi);
    node_t best;
    best = MOST_NEG;
    for (int k = lo; k <= hi; k++) begin
      if (element_values[k] > best) best = element_values[k];
    end
    return best;
  endfunction

  // Build a write; the range fields carry noise the block must ignore
  function automatic tree_op_t write_op(input index_t pos, input node_t value);
    tree_op_t op;
    op.mode       = MODE_WRITE;
    op.position   = pos;
    op.new_value  = value;
    op.range_low  = index_t'($urandom);
    op.range_high = index_t'($urandom);
    return op;
  endfunction

  // Build a query; position and value carry noise the block must ignore
  function automatic tree_op_t query_op(input index_t lo, input index_t hi);
    tree_op_t op;
    op.mode       = MODE_QUERY;
    op.position   = index_t'($urandom);
    op.new_value  = $urandom;
    op.range_low  = lo;
    op.range_high = hi;
    return op;
  endfunction

  // Random traffic: writes clustered at times to force overwrites, queries of assorted spans
  function automatic tree_op_t random_op();
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    index_t      pos;
    node_t       value;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < 55) begin
      pos = (pick < 3) ? index_t'($urandom_range(0, 63)) : index_t'($urandom);
      case ($urandom_range(0, 9))
        0:       value = MOST_NEG;
        1:       value = MOST_POS;
        2, 3:    value = node_t'($signed($urandom_range(0, 20)) - 10);
        default: value = $urandom;
      endcase
      return write_op(pos, value);
    end
    lo = $urandom_range(0, LEAVES - 1);
    hi = $urandom_range(0, LEAVES - 1);
    case (pick)
      0: begin
        lo = $urandom_range(0, 3);
        hi = LEAVES - 1 - $urandom_range(0, 3);
      end
      1: begin
        // force an empty range
        if (lo == 0) lo = 1;
        hi = $urandom_range(0, lo - 1);
      end
      2, 3, 4: begin
        lo = $urandom_range(0, 80);
        hi = lo + $urandom_range(0, 15);
      end
      5, 6: begin
        hi = lo + $urandom_range(0, 31);
        if (hi > LEAVES - 1) hi = LEAVES - 1;
      end
      default: begin
        if (lo > hi) begin
          pick = lo;
          lo   = hi;
          hi   = pick;
        end
      end
    endcase
    return query_op(index_t'(lo), index_t'(hi));
  endfunction

  // Offer one transaction in bursts with random gaps; predict its effect once accepted
  task automatic send_op(input tree_op_t op);
    int unsigned   gap;
    range_answer_t answer;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op.mode;
    in_tdata  <= {2'b00, op.range_high, op.range_low, op.new_value, op.position};
    do @(posedge clk); while (!in_tready);
    if (op.mode == MODE_WRITE) begin
      element_values[op.position] = op.new_value;
      writes_sent++;
    end else begin
      queries_sent++;
      if (op.range_low > op.range_high) begin
        answer.range_maximum = MOST_NEG;
        answer.empty_range   = 1'b1;
        empties_sent++;
      end else begin
        answer.range_maximum = range_maximum_of(op.range_low, op.range_high);
        answer.empty_range   = 1'b0;
      end
      pending_answers = {pending_answers, answer};
    end
  endtask

  // Drop valid and hold until every owed answer is back, then let trailing writes settle
  task automatic wait_for_answers();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Extremes, empty ranges, never-written elements, overwrites and ignored fields
  task automatic test_directed();
    send_op(query_op(0, LEAVES - 1));
    send_op(query_op(7, 6));
    send_op(query_op(LEAVES - 1, 0));
    send_op(write_op(0, MOST_POS));
    send_op(write_op(LEAVES - 1, MOST_NEG));
    send_op(write_op(512, -1));
    send_op(write_op(511, 0));
    send_op(query_op(0, 0));
    send_op(query_op(1, LEAVES - 2));
    send_op(query_op(512, LEAVES - 2));
    send_op(query_op(513, LEAVES - 2));
    send_op(query_op(LEAVES - 1, LEAVES - 1));
    send_op(query_op(0, LEAVES - 1));
    send_op(write_op(0, -2));
    send_op(query_op(0, LEAVES - 1));
    send_op(query_op(0, 0));
    send_op(write_op(LEAVES - 1, MOST_POS));
    send_op(query_op(LEAVES - 2, LEAVES - 1));
    send_op(query_op(1, 0));
    send_op(write_op(341, 32'sh5555_5555));
    send_op(write_op(682, 32'shAAAA_AAAA));
    send_op(query_op(300, 700));
    send_op(query_op(5, 5));
    send_op(query_op(0, LEAVES - 1));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_op(random_op());
  endtask

  // Stall the result side for a long stretch while queries keep coming
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (24) send_op(query_op(index_t'($urandom), LEAVES - 1));
  endtask

  // Pause the sender until the block has delivered everything, several times
  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat (20) send_op(random_op());
      wait_for_answers();
    end
  endtask

  // Receiver: sweep through always-ready, sparse and dense stall patterns; serve long holds
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      rx_cycle++;
      case (rx_cycle[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= (rx_cycle[2:0] != 3'd0) && (rx_cycle[4:3] != 2'd2);
        default: out_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Score each result transaction against the oldest owed answer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: range_maximum %0d empty_range %0b",
               $signed(out_tdata), out_tuser);
        fail_count++;
      end else begin
        seen_answer = pending_answers.pop_front();
        answers_checked++;
        if (node_t'(out_tdata) !== seen_answer.range_maximum) begin
          $error("range_maximum: expected %0d, got %0d",
                 seen_answer.range_maximum, $signed(out_tdata));
          fail_count++;
        end
        if (out_tuser !== seen_answer.empty_range) begin
          $error("empty_range: expected %0b, got %0b", seen_answer.empty_range, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("segment_tree_range_max_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    foreach (element_values[k]) element_values[k] = MOST_NEG;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(380);
    test_output_backpressure();
    test_pause_until_drained();
    wait_for_answers();

    $display("Ran %0d element writes and %0d range queries (%0d empty), %0d results checked.",
             writes_sent, queries_sent, empties_sent, answers_checked);
    $display("Included a %0d-cycle result stall and full drains between bursts.", LONG_HOLD);
    if (fail_count == 0) begin
      $display("segment_tree_range_max_top: match");
    end else begin
      $display("segment_tree_range_max_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- segment_tree_range_max_top.f -----
sv/strmax_pkg.sv
sv/strmax_ram.sv
sv/segment_tree_range_max_top.sv
sv/strmax_chk.sv
bench/segment_tree_range_max_top_tb.sv
